[rtl/srs_pkg.sv]
// ----------------------------------------------------------------------------
// srs_pkg: shared types and constants of the subpixel row shifter
// Payload structs, queue command type and register indexes used by the
// front, the queue, the back end and the top level.
// ----------------------------------------------------------------------------
package srs_pkg;

    localparam int MAX_WIDTH_DEF     = 1024;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHIFT_WHOLE,
        REG_SHIFT_FRACTION,
        REG_SHIFT_LEFT,
        REG_ROW_WIDTH
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       row_end_in;
        logic       drain;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       row_end_out;
    } pix_out_t;

    typedef struct packed {
        logic [23:0] pix1;
        logic [23:0] pix2;
        logic        mix;
        logic        last;
    } cmd_t;

    typedef struct packed {
        logic row_ready;
        logic pend;
    } front_stat_t;

endpackage

[rtl/srs_front.sv]
// ----------------------------------------------------------------------------
// srs_front: input side of the subpixel row shifter
// Holds the configuration registers, the ping-pong row store and the row
// counters, classifies each transaction and reads the two source pixels.
// ----------------------------------------------------------------------------
module srs_front #(
    parameter int MAX_WIDTH     = srs_pkg::MAX_WIDTH_DEF,
    parameter int FRACTION_BITS = srs_pkg::FRACTION_BITS_DEF,
    parameter int QUEUE_DEPTH   = srs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [srs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            pix_valid,
    output logic                            pix_stall,
    input  srs_pkg::pix_in_t                pix_data,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count,
    output srs_pkg::cmd_t                   cmd,
    output srs_pkg::front_stat_t            stat,
    output logic [FRACTION_BITS-1:0]        fraction
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int XW  = ((CW > 10) ? CW : 10) + 2;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int ROWS = 2 ** CW;

    logic [9:0]  shift_whole_reg;
    logic [7:0]  shift_fraction_reg;
    logic        shift_left_reg;
    logic [10:0] row_width_reg;

    logic [CW-1:0] write_col_reg, write_col_next;
    logic [CW-1:0] read_col_reg, read_col_next;
    logic          bank_reg, bank_next;
    logic          ready_reg, ready_next;
    logic          pend_reg;
    logic          mix_reg;
    logic          last_reg;
    logic [23:0]   rd1_reg;
    logic [23:0]   rd2_reg;

    logic [23:0] row_store [0:2*ROWS-1];

    logic [XW-1:0] rw, w, wm1, rc_x, x, sw, jj, a1x, a2x, wc_x, col;
    logic          last, mix, row_end, accept, emit, wr;
    logic [CW:0]   addr1, addr2, waddr;
    logic [QCW:0]  inflight;
    logic [FRACTION_BITS+7:0] fwide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_whole_reg    <= '0;
            shift_fraction_reg <= '0;
            shift_left_reg     <= 1'b0;
            row_width_reg      <= 11'd1024;
        end
        else if (cfg_we)
        begin
            unique case (srs_pkg::cfg_reg_t'(cfg_index))
                srs_pkg::REG_SHIFT_WHOLE:    shift_whole_reg    <= cfg_data[9:0];
                srs_pkg::REG_SHIFT_FRACTION: shift_fraction_reg <= cfg_data[7:0];
                srs_pkg::REG_SHIFT_LEFT:     shift_left_reg     <= cfg_data[0];
                srs_pkg::REG_ROW_WIDTH:      row_width_reg      <= cfg_data[10:0];
            endcase
        end
    end

    assign inflight  = {1'b0, q_count} + {{QCW{1'b0}}, pend_reg};
    assign pix_stall = (inflight >= (QCW+1)'(QUEUE_DEPTH));
    assign accept    = pix_valid && !pix_stall;
    assign emit      = accept && ready_reg;
    assign wr        = accept && !pix_data.drain;

    always_comb
    begin
        rw = XW'(row_width_reg);
        if (rw == '0)
        begin
            w = XW'(1);
        end
        else if (rw > XW'(MAX_WIDTH))
        begin
            w = XW'(MAX_WIDTH);
        end
        else
        begin
            w = rw;
        end
        wm1  = w - XW'(1);
        rc_x = XW'(read_col_reg);
        last = (rc_x >= wm1);
        x    = last ? wm1 : rc_x;
        sw   = XW'(shift_whole_reg);
        if (!shift_left_reg)
        begin
            mix = (x >= sw + XW'(1));
            jj  = x - sw;
            a2x = jj - XW'(1);
        end
        else
        begin
            mix = ((x + sw + XW'(1)) < w);
            jj  = x + sw;
            a2x = jj + XW'(1);
        end
        a1x = mix ? jj : x;
        if (!mix)
        begin
            a2x = x;
        end
        addr1 = {~bank_reg, a1x[CW-1:0]};
        addr2 = {~bank_reg, a2x[CW-1:0]};

        wc_x    = XW'(write_col_reg);
        col     = (wc_x > wm1) ? wm1 : wc_x;
        row_end = pix_data.row_end_in || (col == wm1);
        waddr   = {bank_reg, col[CW-1:0]};

        read_col_next  = read_col_reg;
        ready_next     = ready_reg;
        write_col_next = write_col_reg;
        bank_next      = bank_reg;
        if (emit)
        begin
            if (last)
            begin
                ready_next    = 1'b0;
                read_col_next = '0;
            end
            else
            begin
                read_col_next = CW'(x + XW'(1));
            end
        end
        if (wr)
        begin
            if (row_end)
            begin
                bank_next      = ~bank_reg;
                write_col_next = '0;
                ready_next     = 1'b1;
                read_col_next  = '0;
            end
            else
            begin
                write_col_next = CW'(col + XW'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_col_reg <= '0;
            read_col_reg  <= '0;
            bank_reg      <= 1'b0;
            ready_reg     <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            write_col_reg <= write_col_next;
            read_col_reg  <= read_col_next;
            bank_reg      <= bank_next;
            ready_reg     <= ready_next;
            pend_reg      <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            row_store[waddr] <= {pix_data.red_in, pix_data.green_in, pix_data.blue_in};
        end
        if (emit)
        begin
            rd1_reg  <= row_store[addr1];
            rd2_reg  <= row_store[addr2];
            mix_reg  <= mix;
            last_reg <= last;
        end
    end

    assign fwide    = {{FRACTION_BITS{1'b0}}, shift_fraction_reg};
    assign fraction = fwide[FRACTION_BITS-1:0];

    assign cmd.pix1 = rd1_reg;
    assign cmd.pix2 = rd2_reg;
    assign cmd.mix  = mix_reg;
    assign cmd.last = last_reg;

    assign stat.row_ready = ready_reg;
    assign stat.pend      = pend_reg;

endmodule

[rtl/srs_fifo.sv]
// ----------------------------------------------------------------------------
// srs_fifo: command queue of the subpixel row shifter
// Short first-in first-out queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
module srs_fifo #(
    parameter int QUEUE_DEPTH = srs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  srs_pkg::cmd_t                    push_data,
    input  logic                             pop,
    output srs_pkg::cmd_t                    head,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

    localparam int PW  = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    srs_pkg::cmd_t entries [0:QUEUE_DEPTH-1];

    logic [PW-1:0]  wptr_reg, wptr_next;
    logic [PW-1:0]  rptr_reg, rptr_next;
    logic [QCW-1:0] count_reg, count_next;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wptr_reg] <= push_data;
        end
    end

    assign head  = entries[rptr_reg];
    assign count = count_reg;

endmodule

[rtl/srs_back.sv]
// ----------------------------------------------------------------------------
// srs_back: blend and output stage of the subpixel row shifter
// Takes commands from the queue, blends the two source pixels per channel
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module srs_back #(
    parameter int FRACTION_BITS = srs_pkg::FRACTION_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  srs_pkg::cmd_t            head,
    input  logic                     q_empty,
    input  logic [FRACTION_BITS-1:0] fraction,
    output logic                     pop,
    output logic                     res_valid,
    input  logic                     res_stall,
    output srs_pkg::pix_out_t        res_data
);

    function automatic logic [7:0] mix_chan(
        input logic [7:0]               a,
        input logic [7:0]               b,
        input logic [FRACTION_BITS-1:0] f
    );
        logic signed [8:0]                d;
        logic signed [FRACTION_BITS:0]    fs;
        logic signed [FRACTION_BITS+9:0]  prod;
        logic signed [FRACTION_BITS+9:0]  acc;
        d    = $signed({1'b0, b}) - $signed({1'b0, a});
        fs   = $signed({1'b0, f});
        prod = d * fs;
        acc  = $signed({2'b00, a, {FRACTION_BITS{1'b0}}}) + prod;
        return acc[FRACTION_BITS+7:FRACTION_BITS];
    endfunction

    logic              valid_reg;
    srs_pkg::pix_out_t data_reg;
    srs_pkg::pix_out_t data_next;

    assign pop = !q_empty && (!valid_reg || !res_stall);

    always_comb
    begin
        if (head.mix)
        begin
            data_next.red_out   = mix_chan(head.pix1[23:16], head.pix2[23:16], fraction);
            data_next.green_out = mix_chan(head.pix1[15:8], head.pix2[15:8], fraction);
            data_next.blue_out  = mix_chan(head.pix1[7:0], head.pix2[7:0], fraction);
        end
        else
        begin
            data_next.red_out   = head.pix1[23:16];
            data_next.green_out = head.pix1[15:8];
            data_next.blue_out  = head.pix1[7:0];
        end
        data_next.row_end_out = head.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || !res_stall)
        begin
            valid_reg <= !q_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= data_next;
        end
    end

    assign res_valid = valid_reg;
    assign res_data  = data_reg;

endmodule

[rtl/subpixel_row_shift_rgb_core.sv]
// ----------------------------------------------------------------------------
// subpixel_row_shift_rgb_core: horizontal subpixel row shifter for RGB
// Shifts each raster row by a whole plus fractional pixel amount with a
// per-channel linear blend, using ping-pong row stores.
// ----------------------------------------------------------------------------
// The block takes one pixel transaction per clock while pix_stall is low and
// sustains one result per clock while res_stall is low; an output row appears
// while the next input row is written, so results lag their source by one row,
// and drain transactions push out the last buffered row. A result passes from
// its transaction through the row store read registers (two read ports, one
// write port, 2 x 2**clog2(MAX_WIDTH) entries of 24 bits), the command queue
// and the blend into the output register. When res_stall holds results back,
// the queue of QUEUE_DEPTH commands fills and pix_stall rises. Row store
// entries have no reset and need no clearing pass. The user must write
// configuration only while the block is idle; the block does not enforce it.
module subpixel_row_shift_rgb_core #(
    parameter int MAX_WIDTH     = srs_pkg::MAX_WIDTH_DEF,
    parameter int FRACTION_BITS = srs_pkg::FRACTION_BITS_DEF,
    parameter int QUEUE_DEPTH   = srs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [srs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           pix_valid,
    output logic                           pix_stall,
    input  srs_pkg::pix_in_t               pix_data,
    output logic                           res_valid,
    input  logic                           res_stall,
    output srs_pkg::pix_out_t              res_data
);

    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    srs_pkg::cmd_t            cmd;
    srs_pkg::cmd_t            head;
    srs_pkg::front_stat_t     stat;
    logic [QCW-1:0]           q_count;
    logic                     q_pop;
    logic [FRACTION_BITS-1:0] fraction;

    srs_front #(
        .MAX_WIDTH     (MAX_WIDTH),
        .FRACTION_BITS (FRACTION_BITS),
        .QUEUE_DEPTH   (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .q_count   (q_count),
        .cmd       (cmd),
        .stat      (stat),
        .fraction  (fraction)
    );

    srs_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (stat.pend),
        .push_data (cmd),
        .pop       (q_pop),
        .head      (head),
        .count     (q_count)
    );

    srs_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_count == '0),
        .fraction  (fraction),
        .pop       (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

`ifndef SYNTH
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        stat.pend |-> (q_count < QCW'(QUEUE_DEPTH)))
        else $error("Command queue written while full.");

    a_drain_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && !pix_stall && pix_data.drain && !stat.row_ready) |=> !stat.pend)
        else $error("Drain transaction without a buffered row produced a result.");

    a_ready_row_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && !pix_stall && stat.row_ready) |=> stat.pend)
        else $error("Transaction with a buffered row produced no result.");
`endif

endmodule

[tb/subpixel_row_shift_rgb_core_checker.sv]
// ----------------------------------------------------------------------------
// subpixel_row_shift_rgb_core_checker: result checker of the row shifter
// Watches the configuration port and both pixel channels, keeps its own
// copy of the ping-pong row stores, predicts each shifted pixel and
// compares every result transaction with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module subpixel_row_shift_rgb_core_checker #(
    parameter int MAX_WIDTH     = srs_pkg::MAX_WIDTH_DEF,
    parameter int FRACTION_BITS = srs_pkg::FRACTION_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [srs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           pix_valid,
    input  logic                           pix_stall,
    input  srs_pkg::pix_in_t               pix_data,
    input  logic                           res_valid,
    input  logic                           res_stall,
    input  srs_pkg::pix_out_t              res_data,
    output int                             fail_count,
    output int                             pending_count,
    output int                             result_count
);

    logic [23:0]       line_mem [0:2*MAX_WIDTH-1];
    int                wr_col;
    int                rd_col;
    logic              wr_bank;
    logic              row_ready;
    logic [9:0]        whole_amt;
    logic [7:0]        frac_amt;
    logic              left_dir;
    logic [10:0]       width_reg;
    srs_pkg::pix_out_t shifted_q[$];

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
        result_count  = 0;
    end

    function automatic int eff_width();
        int w;
        w = width_reg;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic logic [7:0] mix_channel(logic [7:0] a, logic [7:0] b, int f);
        int v;
        v = ((1 << FRACTION_BITS) - f) * a + f * b;
        v = v >> FRACTION_BITS;
        return v[7:0];
    endfunction

    task automatic advance_rows(srs_pkg::pix_in_t item);
        int                w;
        int                x;
        int                j;
        int                base;
        int                f;
        int                col;
        logic              last;
        logic              mix;
        logic              ends;
        logic [23:0]       p1;
        logic [23:0]       p2;
        srs_pkg::pix_out_t res;
        w = eff_width();
        if (row_ready)
        begin
            base = wr_bank ? 0 : MAX_WIDTH;
            x    = rd_col;
            last = 1'b0;
            if (x >= w - 1)
            begin
                x    = w - 1;
                last = 1'b1;
            end
            f   = frac_amt & ((1 << FRACTION_BITS) - 1);
            mix = 1'b0;
            j   = 0;
            if (!left_dir)
            begin
                if (x >= int'(whole_amt) + 1)
                begin
                    j   = x - int'(whole_amt);
                    mix = 1'b1;
                end
            end
            else if (x + int'(whole_amt) + 1 < w)
            begin
                j   = x + int'(whole_amt);
                mix = 1'b1;
            end
            if (mix)
            begin
                p1 = line_mem[base + j];
                p2 = left_dir ? line_mem[base + j + 1] : line_mem[base + j - 1];
                res.red_out   = mix_channel(p1[23:16], p2[23:16], f);
                res.green_out = mix_channel(p1[15:8], p2[15:8], f);
                res.blue_out  = mix_channel(p1[7:0], p2[7:0], f);
            end
            else
            begin
                p1 = line_mem[base + x];
                res.red_out   = p1[23:16];
                res.green_out = p1[15:8];
                res.blue_out  = p1[7:0];
            end
            res.row_end_out = last;
            shifted_q.push_back(res);
            if (last)
            begin
                row_ready = 1'b0;
                rd_col    = 0;
            end
            else
            begin
                rd_col = x + 1;
            end
        end
        if (!item.drain)
        begin
            col = wr_col;
            if (col > w - 1) col = w - 1;
            line_mem[(wr_bank ? MAX_WIDTH : 0) + col] =
                {item.red_in, item.green_in, item.blue_in};
            ends = item.row_end_in || (col >= w - 1);
            if (ends)
            begin
                wr_bank   = ~wr_bank;
                wr_col    = 0;
                row_ready = 1'b1;
                rd_col    = 0;
            end
            else
            begin
                wr_col = col + 1;
            end
        end
    endtask

    task automatic check_result(srs_pkg::pix_out_t got);
        srs_pkg::pix_out_t want;
        result_count++;
        if (shifted_q.size() == 0)
        begin
            $error("res_data: expected no transaction, actual %h", got);
            fail_count++;
        end
        else
        begin
            want = shifted_q.pop_front();
            if (got.red_out !== want.red_out)
            begin
                $error("red_out: expected %0d, actual %0d", want.red_out, got.red_out);
                fail_count++;
            end
            if (got.green_out !== want.green_out)
            begin
                $error("green_out: expected %0d, actual %0d", want.green_out, got.green_out);
                fail_count++;
            end
            if (got.blue_out !== want.blue_out)
            begin
                $error("blue_out: expected %0d, actual %0d", want.blue_out, got.blue_out);
                fail_count++;
            end
            if (got.row_end_out !== want.row_end_out)
            begin
                $error("row_end_out: expected %0d, actual %0d",
                       want.row_end_out, got.row_end_out);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_col    = 0;
            rd_col    = 0;
            wr_bank   = 1'b0;
            row_ready = 1'b0;
            whole_amt = '0;
            frac_amt  = '0;
            left_dir  = 1'b0;
            width_reg = 11'd1024;
            shifted_q.delete();
        end
        else
        begin
            if (res_valid && !res_stall)
                check_result(res_data);
            if (cfg_we)
            begin
                case (srs_pkg::cfg_reg_t'(cfg_index))
                    srs_pkg::REG_SHIFT_WHOLE:    whole_amt = cfg_data[9:0];
                    srs_pkg::REG_SHIFT_FRACTION: frac_amt  = cfg_data[7:0];
                    srs_pkg::REG_SHIFT_LEFT:     left_dir  = cfg_data[0];
                    srs_pkg::REG_ROW_WIDTH:      width_reg = cfg_data[10:0];
                    default:                     ;
                endcase
            end
            if (pix_valid && !pix_stall)
                advance_rows(pix_data);
        end
        pending_count = shifted_q.size();
    end

endmodule

[tb/subpixel_row_shift_rgb_core_tb.sv]
// ----------------------------------------------------------------------------
// subpixel_row_shift_rgb_core_tb: testbench top of the row shifter
// Fills both row stores, runs a short directed sequence over the register
// extremes and the row corner cases, then random segments of rows under
// changing shift settings and idle patterns, including one long output
// hold-off. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module subpixel_row_shift_rgb_core_tb;

    localparam int RUN_LIMIT     = 500000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 1000;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [srs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [srs_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           pix_valid = 1'b0;
    logic                           pix_stall;
    srs_pkg::pix_in_t               pix_data  = '0;
    logic                           res_valid;
    logic                           res_stall = 1'b0;
    srs_pkg::pix_out_t              res_data;

    int fail_count;
    int pending_count;
    int result_count;
    int cycle_count    = 0;
    int items_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;

    subpixel_row_shift_rgb_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    subpixel_row_shift_rgb_core_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pix_valid     (pix_valid),
        .pix_stall     (pix_stall),
        .pix_data      (pix_data),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .res_data      (res_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    task automatic send_item(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             logic row_end, logic drain_flag);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= '{red_in: r, green_in: g, blue_in: b,
                       row_end_in: row_end, drain: drain_flag};
        @(posedge clk);
        while (pix_stall) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_row(int len, bit mark_end, int drain_pct);
        for (int i = 0; i < len; i++)
        begin
            while ($urandom_range(0, 99) < drain_pct)
                send_item(8'($urandom), 8'($urandom), 8'($urandom),
                          1'($urandom_range(0, 1)), 1'b1);
            send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), mark_end && (i == len - 1), 1'b0);
        end
    endtask

    task automatic send_drains(int n);
        for (int i = 0; i < n; i++)
            send_item(8'($urandom), 8'($urandom), 8'($urandom),
                      1'($urandom_range(0, 1)), 1'b1);
    endtask

    task automatic settle();
        pix_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(srs_pkg::cfg_reg_t idx, int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[srs_pkg::CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(int whole, int frac, int left, int width);
        settle();
        write_reg(srs_pkg::REG_SHIFT_WHOLE, whole);
        write_reg(srs_pkg::REG_SHIFT_FRACTION, frac);
        write_reg(srs_pkg::REG_SHIFT_LEFT, left);
        write_reg(srs_pkg::REG_ROW_WIDTH, width);
    endtask

    initial
    begin : stimulus
        int seg;
        int roll;
        int width;
        int w_eff;
        int whole;
        int frac;
        int nrows;
        int len;
        int start_items;
        int big_rows;
        bit pressure;

        seg      = 0;
        big_rows = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Write every entry of both row stores, the first row ending on the width alone.
        send_row(1024, 1'b0, 0);
        configure(0, 0, 0, 2047);
        send_row(1024, 1'b1, 0);

        configure(1, 255, 0, 4);
        send_drains(4);
        send_item(8'h12, 8'h34, 8'h56, 1'b0, 1'b1);
        send_item(8'h65, 8'h43, 8'h21, 1'b1, 1'b1);

        settle();
        send_item(8'hff, 8'hff, 8'hff, 1'b0, 1'b0);
        send_item(8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        send_item(8'hff, 8'h00, 8'hff, 1'b0, 1'b0);
        send_item(8'h00, 8'hff, 8'h00, 1'b1, 1'b0);
        send_item(8'h80, 8'h7f, 8'h01, 1'b0, 1'b0);
        send_item(8'h7f, 8'h80, 8'hfe, 1'b1, 1'b0);
        send_drains(4);

        configure(1023, 0, 1, 0);
        send_row(3, 1'b0, 0);
        send_drains(1);

        configure(2, 64, 0, 6);
        send_row(6, 1'b1, 0);
        send_drains(4);
        settle();
        write_reg(srs_pkg::REG_ROW_WIDTH, 2);
        send_drains(1);

        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS)
        begin
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            pressure = (seg == 6);

            roll = $urandom_range(0, 99);
            if (pressure)
                width = 8;
            else if (roll < 60)
                width = $urandom_range(1, 8);
            else if (roll < 85)
                width = $urandom_range(9, 32);
            else if (roll < 95)
                width = $urandom_range(33, 100);
            else if (roll < 98 || big_rows >= 2)
                width = $urandom_range(0, 2);
            else
            begin
                width = $urandom_range(1024, 2047);
                big_rows++;
            end
            w_eff = (width == 0) ? 1 : ((width > 1024) ? 1024 : width);

            roll = $urandom_range(0, 99);
            if (roll < 70)
                whole = $urandom_range(0, w_eff);
            else if (roll < 85)
                whole = $urandom_range(0, 1023);
            else
                whole = $urandom_range(0, 1) ? 1023 : 0;

            roll = $urandom_range(0, 99);
            frac = (roll < 15) ? 0 : ((roll < 30) ? 255 : $urandom_range(0, 255));

            configure(whole, frac, $urandom_range(0, 1), width);
            if (pressure)
                hold_request = 1'b1;

            nrows = (w_eff > 100) ? 1 : (pressure ? 6 : $urandom_range(1, 4));
            for (int r = 0; r < nrows; r++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 80 || w_eff == 1)
                    send_row(w_eff, 1'($urandom_range(0, 1)), 3);
                else if (roll < 92)
                    send_row($urandom_range(1, w_eff - 1), 1'b1, 3);
                else
                    send_row(w_eff + $urandom_range(1, 3), 1'b0, 10);
            end

            if ($urandom_range(0, 99) < 80)
                send_drains(w_eff);
            else
                send_drains($urandom_range(0, w_eff - 1));
            seg++;
        end

        settle();
        repeat (20) @(negedge clk);
        $display("Covered %0d input transactions, %0d results checked, %0d random segments.",
                 items_sent, result_count, seg);
        $display("Widths 0 to 2047, both directions, fraction extremes and a long hold-off.");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
